@@ hw/rtl/gls_pkg.sv @@
package gls_pkg;

   // map geometry
   localparam int MAP_SIDE = 64;
   localparam int TILE_COUNT = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_W = $clog2(TILE_COUNT);

   // coordinate and error term widths
   localparam int COORD_W = 6;
   localparam int ERR_W = COORD_W + 3;

   // request and response bus widths
   localparam int REQ_FIELDS_W = 4 * COORD_W + 1;
   localparam int REQ_DATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   // request kinds carried on tuser
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // sequencer states
   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] S_IDLE  = 2'd0;
   localparam logic [STATE_W-1:0] S_WALK  = 2'd1;
   localparam logic [STATE_W-1:0] S_DRAIN = 2'd2;
   localparam logic [STATE_W-1:0] S_HOLD  = 2'd3;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic signed [ERR_W-1:0] err_type;

endpackage

@@ hw/rtl/gls_ram.sv @@
module gls_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/grid_line_of_sight_core.sv @@
// a write request gives no response; a query gives its response when its walk of major
//    steps, major = max(|dx|,|dy|), ends at the last tile, or earlier at a blocking tile
// throughput: one query at a time, one tile per cycle, set by the single tile map read port;
//    the next request is taken once the query's result is in the response register, writes back to back
// reset: clears the sequencer and the response valid flag; the tile map is not cleared
module grid_line_of_sight_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x, start_y, end_x, end_y, blocks_sight, zero fill
   input  logic [gls_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // visible, zero fill
   output logic [gls_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import gls_pkg::*;

   // request fields
   coord_type req_sx, req_sy, req_ex, req_ey;
   logic      req_mark;
   logic      req_fire;

   // accept-time line setup
   coord_type dx, dy, major, minor;
   logic      x_neg, y_neg, x_major_new;
   err_type   err_init, inc_min_new, inc_diag_new;
   logic      req_oob;

   // walk registers
   logic [STATE_W-1:0] state_ff, state_in;
   coord_type x_ff, x_in, y_ff, y_in, cnt_ff, cnt_in;
   err_type   err_ff, err_in, inc_min_ff, inc_min_in, inc_diag_ff, inc_diag_in;
   logic      x_neg_ff, x_neg_in, y_neg_ff, y_neg_in, x_major_ff, x_major_in;
   logic      pend_valid_ff, pend_valid_in, pend_last_ff, pend_last_in;
   logic      pend_oob_ff, pend_oob_in;
   logic      hold_vis_ff, hold_vis_in;
   logic      rsp_valid_ff, rsp_valid_in, rsp_visible_ff, rsp_visible_in;

   // step logic
   logic      side, step_x, step_y, tile_oob, blocked_pend, slot_free;
   logic      finish, finish_vis;
   err_type   err_next;
   coord_type x_next, y_next;

   // map port
   logic              map_wr_en, map_rd_en, map_rd_data;
   logic [ADDR_W-1:0] map_wr_addr, map_rd_addr;

   // field unpacking
   assign req_sx   = req_tdata[COORD_W-1:0];
   assign req_sy   = req_tdata[2*COORD_W-1:COORD_W];
   assign req_ex   = req_tdata[3*COORD_W-1:2*COORD_W];
   assign req_ey   = req_tdata[4*COORD_W-1:3*COORD_W];
   assign req_mark = req_tdata[4*COORD_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // line setup from the request
   always_comb begin
      x_neg = (req_ex < req_sx);
      y_neg = (req_ey < req_sy);
      dx = x_neg ? (req_sx - req_ex) : (req_ex - req_sx);
      dy = y_neg ? (req_sy - req_ey) : (req_ey - req_sy);
      x_major_new = (dy <= dx);
      major = x_major_new ? dx : dy;
      minor = x_major_new ? dy : dx;
      inc_min_new  = $signed({{(ERR_W-COORD_W-1){1'b0}}, minor, 1'b0});
      err_init     = inc_min_new - $signed({{(ERR_W-COORD_W){1'b0}}, major});
      inc_diag_new = inc_min_new - $signed({{(ERR_W-COORD_W-1){1'b0}}, major, 1'b0});
   end

   // tile map write on write requests inside the map
   assign req_oob = (int'(req_sx) >= MAP_SIDE) || (int'(req_sy) >= MAP_SIDE);
   assign map_wr_en   = req_fire && (req_tuser == KIND_WRITE) && !req_oob;
   assign map_wr_addr = ADDR_W'(int'(req_sy) * MAP_SIDE + int'(req_sx));
   assign map_rd_addr = ADDR_W'(int'(y_ff) * MAP_SIDE + int'(x_ff));

   gls_ram #(
      .WIDTH (1),
      .DEPTH (TILE_COUNT)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (req_mark),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // one bresenham step
   always_comb begin
      side     = !err_ff[ERR_W-1] && (err_ff != '0);
      err_next = side ? (err_ff + inc_diag_ff) : (err_ff + inc_min_ff);
      step_x   = x_major_ff || side;
      step_y   = !x_major_ff || side;
      x_next   = step_x ? (x_neg_ff ? x_ff - 1'b1 : x_ff + 1'b1) : x_ff;
      y_next   = step_y ? (y_neg_ff ? y_ff - 1'b1 : y_ff + 1'b1) : y_ff;
   end

   // check of the tile read last cycle
   assign tile_oob     = (int'(x_ff) >= MAP_SIDE) || (int'(y_ff) >= MAP_SIDE);
   assign blocked_pend = pend_valid_ff && (pend_oob_ff || map_rd_data);
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign map_rd_en    = (state_ff == S_WALK) && !blocked_pend;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      inc_min_in    = inc_min_ff;
      inc_diag_in   = inc_diag_ff;
      x_neg_in      = x_neg_ff;
      y_neg_in      = y_neg_ff;
      x_major_in    = x_major_ff;
      pend_valid_in = 1'b0;
      pend_last_in  = pend_last_ff;
      pend_oob_in   = pend_oob_ff;
      hold_vis_in   = hold_vis_ff;
      finish        = 1'b0;
      finish_vis    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_tuser == KIND_QUERY)) begin
               state_in    = S_WALK;
               x_in        = req_sx;
               y_in        = req_sy;
               cnt_in      = major;
               err_in      = err_init;
               inc_min_in  = inc_min_new;
               inc_diag_in = inc_diag_new;
               x_neg_in    = x_neg;
               y_neg_in    = y_neg;
               x_major_in  = x_major_new;
            end
         end
         S_WALK: begin
            if (blocked_pend) begin
               finish = 1'b1;
            end else begin
               pend_valid_in = 1'b1;
               pend_last_in  = (cnt_ff == '0);
               pend_oob_in   = tile_oob;
               if (cnt_ff == '0) begin
                  state_in = S_DRAIN;
               end else begin
                  x_in   = x_next;
                  y_in   = y_next;
                  err_in = err_next;
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         S_DRAIN: begin
            finish     = 1'b1;
            finish_vis = !blocked_pend;
         end
         S_HOLD: begin
            finish_vis = hold_vis_ff;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         hold_vis_in = finish_vis;
         state_in    = slot_free ? S_IDLE : S_HOLD;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_visible_in = rsp_visible_ff;
      if ((finish || (state_ff == S_HOLD)) && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_visible_in = finish_vis;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      cnt_ff         <= cnt_in;
      err_ff         <= err_in;
      inc_min_ff     <= inc_min_in;
      inc_diag_ff    <= inc_diag_in;
      x_neg_ff       <= x_neg_in;
      y_neg_ff       <= y_neg_in;
      x_major_ff     <= x_major_in;
      pend_last_ff   <= pend_last_in;
      pend_oob_ff    <= pend_oob_in;
      hold_vis_ff    <= hold_vis_in;
      rsp_visible_ff <= rsp_visible_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, rsp_visible_ff};

   // a query always starts a walk
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == KIND_QUERY)) |=> (state_ff == S_WALK))
      else $error("query did not start a walk");

   // a write never raises a response
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == KIND_WRITE) && !rsp_valid_ff) |=> !rsp_tvalid)
      else $error("write produced a response");

   // a held result only waits behind an occupied response register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff)
      else $error("hold state with free response register");

   // drain always checks the last tile of the line
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (pend_valid_ff && pend_last_ff))
      else $error("drain without last tile pending");

endmodule
